/* hw/rtl/rbp_pkg.sv */
package rbp_pkg;

   localparam int HDR_BYTES       = 16;
   localparam int MAX_REC_BYTES   = 65535;
   localparam int MTU_FLOOR       = 1100;
   localparam int MTU_RESET       = 1200;
   localparam int NS_PER_US       = 1000;
   localparam int QUEUE_DEPTH_DEF = 2;

   // item opcodes
   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_RECORD = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   // packet kinds
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_BATCH = 2'd1;
   localparam logic [1:0] KIND_SEG   = 2'd2;
   localparam logic [1:0] KIND_END   = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_MTU      = 2'd0;
   localparam logic [1:0] CSR_DEADLINE = 2'd1;
   localparam logic [1:0] CSR_LIMIT    = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] ts;
      logic [15:0] len;
      logic [63:0] now;
      logic [16:0] rec_size;
      logic        oversize;
   } cmd_type;

   typedef struct packed {
      logic [15:0] mtu;
      logic [29:0] dl_ns;
      logic        dl_en;
      logic [31:0] limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] seq;
      logic [15:0] recs;
      logic [15:0] bytes;
      logic [15:0] off;
      logic [63:0] seg_ts;
      logic [63:0] sum_rec;
      logic [63:0] sum_pay;
      logic [63:0] sum_dp;
      logic [63:0] first_t;
      logic [63:0] last_t;
      logic        last;
   } pkt_type;

endpackage

/* hw/rtl/rbp_front.sv */
module rbp_front (
   input  logic             clock,
   input  logic             reset,
   input  rbp_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [1:0]       in_op,
   input  logic [63:0]      in_ts,
   input  logic [15:0]      in_len,
   input  logic [63:0]      in_now,
   output logic             push_valid,
   input  logic             push_ready,
   output rbp_pkg::cmd_type push_data
);
   import rbp_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   cmd_type cmd_ff;
   cmd_type cmd_in;
   logic [15:0] len_clamp;

   assign in_ready   = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_data  = cmd_ff;

   always_comb begin
      len_clamp = (32'(in_len) > MAX_REC_BYTES) ? 16'(MAX_REC_BYTES) : in_len;
      cmd_in.op        = in_op;
      cmd_in.ts        = in_ts;
      cmd_in.len       = len_clamp;
      cmd_in.now       = in_now;
      cmd_in.rec_size  = 17'(HDR_BYTES) + {1'b0, len_clamp};
      cmd_in.oversize  = cmd_in.rec_size > {1'b0, cfg.mtu};
      // drop unknown opcodes here, they cause no packets
      if (in_valid && in_ready) begin
         valid_in = (in_op != OP_NONE);
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

/* hw/rtl/rbp_queue.sv */
module rbp_queue #(
   parameter int DEPTH = rbp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  rbp_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output rbp_pkg::cmd_type pop_data
);
   import rbp_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type        mem [DEPTH];
   logic [PW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           do_push, do_pop;

   assign push_ready = cnt_ff < CW'(DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = mem[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem[wr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/rbp_back.sv */
module rbp_back (
   input  logic             clock,
   input  logic             reset,
   input  rbp_pkg::cfg_type cfg,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  rbp_pkg::cmd_type pop_data,
   output logic             out_valid,
   input  logic             out_ready,
   output rbp_pkg::pkt_type out_pkt
);
   import rbp_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EVAL  = 3'd1;
   localparam logic [2:0] S_START = 3'd2;
   localparam logic [2:0] S_FLUSH = 3'd3;
   localparam logic [2:0] S_SEG   = 3'd4;
   localparam logic [2:0] S_ADD   = 3'd5;
   localparam logic [2:0] S_DLFL  = 3'd6;
   localparam logic [2:0] S_END   = 3'd7;

   logic [2:0]  st_ff, st_in;
   cmd_type     cmd_ff, cmd_in;
   logic        ovf_ff, ovf_in, dlhit_ff, dlhit_in;
   logic [16:0] obytes_ff, obytes_in;
   logic [15:0] orecs_ff, orecs_in;
   logic [63:0] seq_ff, seq_in, rtot_ff, rtot_in, btot_ff, btot_in;
   logic [63:0] dtot_ff, dtot_in, first_ff, first_in, lastt_ff, lastt_in;
   logic [63:0] bot_ff, bot_in, cnt_ff, cnt_in;
   logic [15:0] off_ff, off_in;
   pkt_type     out_ff, out_in;
   logic        oval_ff, oval_in;

   logic        out_free;
   logic [15:0] max_seg, remain, seg;
   logic        seg_last;
   logic        lim_hit;
   logic [63:0] age;

   assign out_valid = oval_ff;
   assign out_pkt   = out_ff;
   assign out_free  = !oval_ff || out_ready;

   function automatic pkt_type mk(input logic [1:0] kind, input logic [63:0] seq,
                                  input logic [15:0] recs, input logic [15:0] bytes,
                                  input logic [15:0] off, input logic [63:0] ts,
                                  input logic last);
      pkt_type p;
      p        = '0;
      p.kind   = kind;
      p.seq    = seq;
      p.recs   = recs;
      p.bytes  = bytes;
      p.off    = off;
      p.seg_ts = ts;
      p.last   = last;
      return p;
   endfunction

   always_comb begin
      max_seg  = cfg.mtu - 16'(HDR_BYTES);
      remain   = cmd_ff.len - off_ff;
      seg_last = remain <= max_seg;
      seg      = seg_last ? remain : max_seg;
      lim_hit  = (cfg.limit != '0) && (cnt_ff >= {32'b0, cfg.limit});
      age      = cmd_ff.now - bot_ff;

      st_in     = st_ff;
      cmd_in    = cmd_ff;
      ovf_in    = ovf_ff;
      dlhit_in  = dlhit_ff;
      obytes_in = obytes_ff;
      orecs_in  = orecs_ff;
      seq_in    = seq_ff;
      rtot_in   = rtot_ff;
      btot_in   = btot_ff;
      dtot_in   = dtot_ff;
      first_in  = first_ff;
      lastt_in  = lastt_ff;
      bot_in    = bot_ff;
      cnt_in    = cnt_ff;
      off_in    = off_ff;
      out_in    = out_ff;
      oval_in   = oval_ff && !out_ready;
      pop_ready = 1'b0;

      unique case (st_ff)
         S_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               cmd_in = pop_data;
               off_in = '0;
               st_in  = S_EVAL;
            end
         end
         S_EVAL: begin
            unique case (cmd_ff.op)
               OP_START: st_in = S_START;
               OP_RECORD: begin
                  if (lim_hit) begin
                     st_in = S_IDLE;
                  end else if (cmd_ff.oversize) begin
                     st_in = (orecs_ff != '0) ? S_FLUSH : S_SEG;
                  end else begin
                     ovf_in   = (orecs_ff != '0) &&
                                ({1'b0, obytes_ff} + {1'b0, cmd_ff.rec_size} >
                                 {2'b0, cfg.mtu});
                     dlhit_in = cfg.dl_en && (age >= {34'b0, cfg.dl_ns});
                     st_in    = S_ADD;
                  end
               end
               OP_FINISH: st_in = (orecs_ff != '0) ? S_FLUSH : S_END;
               default:   st_in = S_IDLE;
            endcase
         end
         S_START: begin
            if (out_free) begin
               out_in  = mk(KIND_START, seq_ff, '0, '0, '0, '0, 1'b1);
               oval_in = 1'b1;
               seq_in  = seq_ff + 1'b1;
               bot_in  = cmd_ff.now;
               st_in   = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               out_in    = mk(KIND_BATCH, seq_ff, orecs_ff, obytes_ff[15:0], '0, '0, 1'b0);
               oval_in   = 1'b1;
               seq_in    = seq_ff + 1'b1;
               dtot_in   = dtot_ff + 1'b1;
               first_in  = (first_ff == '0) ? cmd_ff.now : first_ff;
               lastt_in  = cmd_ff.now;
               obytes_in = '0;
               orecs_in  = '0;
               st_in     = (cmd_ff.op == OP_FINISH) ? S_END : S_SEG;
            end
         end
         S_SEG: begin
            if (out_free) begin
               out_in   = mk(KIND_SEG, seq_ff, 16'd1, seg + 16'(HDR_BYTES), off_ff,
                             cmd_ff.ts, seg_last);
               oval_in  = 1'b1;
               seq_in   = seq_ff + 1'b1;
               dtot_in  = dtot_ff + 1'b1;
               first_in = (first_ff == '0) ? cmd_ff.now : first_ff;
               lastt_in = cmd_ff.now;
               rtot_in  = rtot_ff + 1'b1;
               btot_in  = btot_ff + {48'b0, seg};
               cnt_in   = cnt_ff + 1'b1;
               off_in   = off_ff + seg;
               if (seg_last) begin
                  st_in = S_IDLE;
               end
            end
         end
         S_ADD: begin
            if (ovf_ff) begin
               // flush the full batch, then open a new one with this record
               if (out_free) begin
                  out_in    = mk(KIND_BATCH, seq_ff, orecs_ff, obytes_ff[15:0], '0, '0, 1'b1);
                  oval_in   = 1'b1;
                  seq_in    = seq_ff + 1'b1;
                  dtot_in   = dtot_ff + 1'b1;
                  first_in  = (first_ff == '0) ? cmd_ff.now : first_ff;
                  lastt_in  = cmd_ff.now;
                  bot_in    = cmd_ff.now;
                  obytes_in = cmd_ff.rec_size;
                  orecs_in  = 16'd1;
                  rtot_in   = rtot_ff + 1'b1;
                  btot_in   = btot_ff + {48'b0, cmd_ff.len};
                  cnt_in    = cnt_ff + 1'b1;
                  st_in     = S_IDLE;
               end
            end else begin
               obytes_in = obytes_ff + cmd_ff.rec_size;
               orecs_in  = orecs_ff + 1'b1;
               rtot_in   = rtot_ff + 1'b1;
               btot_in   = btot_ff + {48'b0, cmd_ff.len};
               cnt_in    = cnt_ff + 1'b1;
               st_in     = dlhit_ff ? S_DLFL : S_IDLE;
            end
         end
         S_DLFL: begin
            if (out_free) begin
               out_in    = mk(KIND_BATCH, seq_ff, orecs_ff, obytes_ff[15:0], '0, '0, 1'b1);
               oval_in   = 1'b1;
               seq_in    = seq_ff + 1'b1;
               dtot_in   = dtot_ff + 1'b1;
               first_in  = (first_ff == '0) ? cmd_ff.now : first_ff;
               lastt_in  = cmd_ff.now;
               bot_in    = cmd_ff.now;
               obytes_in = '0;
               orecs_in  = '0;
               st_in     = S_IDLE;
            end
         end
         S_END: begin
            if (out_free) begin
               out_in         = mk(KIND_END, seq_ff, '0, '0, '0, '0, 1'b1);
               out_in.sum_rec = rtot_ff;
               out_in.sum_pay = btot_ff;
               out_in.sum_dp  = dtot_ff;
               out_in.first_t = first_ff;
               out_in.last_t  = lastt_ff;
               oval_in        = 1'b1;
               seq_in         = seq_ff + 1'b1;
               st_in          = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_IDLE;
         oval_ff   <= 1'b0;
         obytes_ff <= '0;
         orecs_ff  <= '0;
         seq_ff    <= '0;
         rtot_ff   <= '0;
         btot_ff   <= '0;
         dtot_ff   <= '0;
         first_ff  <= '0;
         lastt_ff  <= '0;
         bot_ff    <= '0;
         cnt_ff    <= '0;
      end else begin
         st_ff     <= st_in;
         oval_ff   <= oval_in;
         obytes_ff <= obytes_in;
         orecs_ff  <= orecs_in;
         seq_ff    <= seq_in;
         rtot_ff   <= rtot_in;
         btot_ff   <= btot_in;
         dtot_ff   <= dtot_in;
         first_ff  <= first_in;
         lastt_ff  <= lastt_in;
         bot_ff    <= bot_in;
         cnt_ff    <= cnt_in;
      end
      cmd_ff   <= cmd_in;
      ovf_ff   <= ovf_in;
      dlhit_ff <= dlhit_in;
      off_ff   <= off_in;
      out_ff   <= out_in;
   end

endmodule

/* hw/rtl/record_batch_packetizer_top.sv */
// Channel  | Direction | Handshake              | Content
// req      | in        | req_tvalid/req_tready  | op in tuser, descriptor in tdata
// rsp      | out       | rsp_tvalid/rsp_tready  | kind in tuser, last in tlast, packet in tdata
// csr      | in        | csr_we                 | register write, no read-back
//
// Sequencing: the sequencer serves one item at a time; it fetches and classifies each,
// then emits a start packet, adds a fitting record (flushing on overflow or deadline),
// flushes and ends on finish, or flushes and segments an oversize record.
// Reset: synchronous, active high; clears totals, stamps and the open batch, loads an
// MTU of 1200, deadline off, no record limit.
// Stalls: front and queue keep taking items until full; a packet waits in the output register.
module record_batch_packetizer_top #(
   parameter int QUEUE_DEPTH = rbp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // op
   input  logic [143:0] req_tdata,   // record_ts, len, now
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [1:0]   rsp_tuser,   // kind
   output logic         rsp_tlast,   // last
   output logic [495:0] rsp_tdata,   // seq, recs_in_packet, packet_bytes, seg_offset,
                                     // seg_ts, sum_records, sum_payload_bytes,
                                     // sum_data_packets, first_send_time, last_send_time
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   import rbp_pkg::*;

   logic [15:0] mtu_ff;
   logic [29:0] dl_ns_ff;
   logic        dl_en_ff;
   logic [31:0] limit_ff;
   cfg_type     cfg;

   logic        q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
   cmd_type     q_push_data, q_pop_data;
   pkt_type     pkt;

   // Registers: clamp the MTU up to its floor, keep the deadline as nanoseconds
   always_ff @(posedge clock) begin
      if (reset) begin
         mtu_ff   <= 16'(MTU_RESET);
         dl_ns_ff <= '0;
         dl_en_ff <= 1'b0;
         limit_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MTU: begin
               mtu_ff <= (csr_wdata[15:0] < 16'(MTU_FLOOR)) ? 16'(MTU_FLOOR)
                                                            : csr_wdata[15:0];
            end
            CSR_DEADLINE: begin
               dl_ns_ff <= 30'(csr_wdata[19:0]) * 30'(NS_PER_US);
               dl_en_ff <= csr_wdata[19:0] != '0;
            end
            CSR_LIMIT: limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.mtu   = mtu_ff;
   assign cfg.dl_ns = dl_ns_ff;
   assign cfg.dl_en = dl_en_ff;
   assign cfg.limit = limit_ff;

   // Front: take items, classify against the MTU, drop unknown opcodes
   rbp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_op      (req_tuser),
      .in_ts      (req_tdata[63:0]),
      .in_len     (req_tdata[79:64]),
      .in_now     (req_tdata[143:80]),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data)
   );

   // Command queue between front and sequencer
   rbp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data)
   );

   // Back: batch state, totals and packet sequencing
   rbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (q_pop_valid),
      .pop_ready (q_pop_ready),
      .pop_data  (q_pop_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pkt   (pkt)
   );

   assign rsp_tuser = pkt.kind;
   assign rsp_tlast = pkt.last;
   assign rsp_tdata = {pkt.last_t, pkt.first_t, pkt.sum_dp, pkt.sum_pay, pkt.sum_rec,
                       pkt.seg_ts, pkt.off, pkt.bytes, pkt.recs, pkt.seq};

endmodule
